>>> hw/rtl/pcf_pkg.sv
// Shared constants, types and index helpers of the packed Cholesky factor block.
package pcf_pkg;

  localparam int MAX_ORDER     = 8;
  localparam int FRACTION_BITS = 16;
  localparam int DEPTH         = MAX_ORDER * (MAX_ORDER + 1) / 2;
  localparam int ORD_W         = 4;
  localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int DATA_W        = 32;
  localparam int ACC_W         = 64;
  localparam int ITER_W        = 6;
  localparam int SQRT_STEPS    = ACC_W / 2;
  localparam int DIV_STEPS     = ACC_W;

  typedef logic [ORD_W-1:0]  order_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [11:0] {
    ST_LOAD  = 12'b0000_0000_0001,
    ST_RDIN  = 12'b0000_0000_0010,
    ST_INIT  = 12'b0000_0000_0100,
    ST_RDF   = 12'b0000_0000_1000,
    ST_MUL   = 12'b0000_0001_0000,
    ST_SUB   = 12'b0000_0010_0000,
    ST_POST  = 12'b0000_0100_0000,
    ST_SQRT  = 12'b0000_1000_0000,
    ST_DIV   = 12'b0001_0000_0000,
    ST_WR    = 12'b0010_0000_0000,
    ST_FAIL  = 12'b0100_0000_0000,
    ST_EMIT  = 12'b1000_0000_0000
  } state_t;

  localparam logic REG_ORDER = 1'b0;

  // Packed row start: v*(v+1)/2.
  function automatic cnt_t tri_num(input order_t v);
    logic [2*ORD_W:0] p;
    p = {{(ORD_W+1){1'b0}}, v} * {{ORD_W{1'b0}}, {1'b0, v} + {{ORD_W{1'b0}}, 1'b1}};
    return CNT_W'(p >> 1);
  endfunction

endpackage

>>> hw/rtl/packed_cholesky_factor.sv
// Packed Cholesky factor: load, factorize in memory, stream out the factor.
//
// Usage: program matrix_order over the APB port (byte address 0, bits 3:0;
// 0 acts as 1, values above 8 act as 8). Any write to it restarts loading.
// Send the packed lower triangle, row by row, one Q16.16 element per beat on
// the in_ channel. While loading, one beat is taken every cycle.
// After the last element in_stall rises and the factorization runs out of
// two 36-word memories (input and factor, registered reads). Each factor
// entry takes a read and setup step, then a multiply-subtract per prior
// term k, then a digit-by-digit square root (diagonal) or a bit-serial
// restoring division (off-diagonal), and is then written back.
// The factor then streams out, each beat waiting on its registered read,
// with last_of_run on the final beat. A non-positive pivot ends the run
// with a single beat (0, not_positive_definite, last_of_run).
// A stalled result holds in the output register; the block waits on it and
// resumes loading once the final beat is registered.
// Reset: order 8, load count 0, output empty; memories are not cleared.
module packed_cholesky_factor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_element_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_factor_value,
  output logic        out_not_positive_definite,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DW = pcf_pkg::DATA_W;
  localparam int AW = pcf_pkg::ACC_W;
  localparam int OW = pcf_pkg::ORD_W;

  // Memories
  logic [DW-1:0] in_mem  [pcf_pkg::DEPTH];
  logic [DW-1:0] fac_mem [pcf_pkg::DEPTH];
  logic [DW-1:0] in_q, fa_q, fb_q;
  pcf_pkg::addr_t in_raddr, fa_addr, fb_addr, wr_addr;
  logic           fac_we;
  logic [DW-1:0]  fac_wdata;

  // Control and datapath registers
  pcf_pkg::state_t state_r, state_nxt;
  pcf_pkg::order_t order_r;
  pcf_pkg::cnt_t   load_cnt_r, emit_r;
  pcf_pkg::order_t i_r, j_r, k_r;
  logic [pcf_pkg::ITER_W-1:0] iter_r;
  logic signed [AW-1:0] acc_r, prod_r;
  logic [AW-1:0] shf_r;
  logic [33:0]   rem_r;
  logic [AW-1:0] q_r;
  logic          neg_r;
  logic [DW-1:0] diag_r;
  logic          ov_r, onpd_r, olast_r;
  logic [DW-1:0] oval_r;
  // Emit waits after each address change for the registered read data
  logic          emit_wait_r;

  pcf_pkg::order_t n_eff;
  pcf_pkg::cnt_t   total;
  logic cfg_wr, in_acc, out_free, is_diag, ov_load;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == pcf_pkg::REG_ORDER);
  assign prdata = (paddr[2] == pcf_pkg::REG_ORDER) ? {{(32-OW){1'b0}}, order_r} : 32'd0;

  always_comb begin
    if (order_r == '0) n_eff = OW'(1);
    else if (order_r > OW'(pcf_pkg::MAX_ORDER)) n_eff = OW'(pcf_pkg::MAX_ORDER);
    else n_eff = order_r;
  end
  assign total = pcf_pkg::tri_num(n_eff);

  assign in_stall = (state_r != pcf_pkg::ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;
  assign is_diag  = (i_r == j_r);
  // Load the output register with a failure beat or the next factor beat
  assign ov_load  = out_free && ((state_r == pcf_pkg::ST_FAIL) ||
                                 ((state_r == pcf_pkg::ST_EMIT) && !emit_wait_r));

  // Memory addressing
  assign in_raddr = pcf_pkg::ADDR_W'(pcf_pkg::tri_num(j_r) + pcf_pkg::CNT_W'(i_r));
  assign wr_addr  = in_raddr;
  assign fb_addr  = pcf_pkg::ADDR_W'(pcf_pkg::tri_num(j_r) + pcf_pkg::CNT_W'(k_r));
  assign fa_addr  = (state_r == pcf_pkg::ST_RDF) ?
                    pcf_pkg::ADDR_W'(pcf_pkg::tri_num(i_r) + pcf_pkg::CNT_W'(k_r)) :
                    pcf_pkg::ADDR_W'(emit_r);

  always_ff @(posedge clk) begin
    if (in_acc) in_mem[pcf_pkg::ADDR_W'(load_cnt_r)] <= in_element_value;
    in_q <= in_mem[in_raddr];
  end

  always_ff @(posedge clk) begin
    if (fac_we) fac_mem[wr_addr] <= fac_wdata;
    fa_q <= fac_mem[fa_addr];
    fb_q <= fac_mem[fb_addr];
  end

  // Saturating subtract on the accumulator
  function automatic logic signed [AW-1:0] sat_sub(input logic signed [AW-1:0] a,
                                                   input logic signed [AW-1:0] p);
    logic [AW:0] d;
    d = {a[AW-1], a} - {p[AW-1], p};
    if (d[AW] != d[AW-1]) return d[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    return d[AW-1:0];
  endfunction

  // One root digit and one quotient bit per cycle
  logic [33:0] sq_rem_t, sq_trial;
  logic        sq_ge;
  logic [32:0] dv_rem_t;
  logic        dv_ge;
  assign sq_rem_t = {rem_r[31:0], shf_r[AW-1 -: 2]};
  assign sq_trial = {q_r[31:0], 2'b01};
  assign sq_ge    = (sq_rem_t >= sq_trial);
  assign dv_rem_t = {rem_r[31:0], shf_r[AW-1]};
  assign dv_ge    = (dv_rem_t >= {1'b0, diag_r});

  // Final entry value
  logic [DW-1:0] res_val;
  always_comb begin
    if (is_diag) begin
      res_val = q_r[31] ? 32'h7fff_ffff : q_r[31:0];
    end else if (!neg_r) begin
      res_val = (q_r[AW-1:31] != '0) ? 32'h7fff_ffff : q_r[31:0];
    end else begin
      res_val = (q_r[AW-1:31] != '0) ? 32'h8000_0000 : (32'd0 - q_r[31:0]);
    end
  end
  assign fac_we    = (state_r == pcf_pkg::ST_WR);
  assign fac_wdata = res_val;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcf_pkg::ST_LOAD: begin
        if (in_acc && !cfg_wr && (load_cnt_r + pcf_pkg::CNT_W'(1) >= total))
          state_nxt = pcf_pkg::ST_RDIN;
      end
      pcf_pkg::ST_RDIN: state_nxt = pcf_pkg::ST_INIT;
      pcf_pkg::ST_INIT: state_nxt = (i_r == '0) ? pcf_pkg::ST_POST : pcf_pkg::ST_RDF;
      pcf_pkg::ST_RDF:  state_nxt = pcf_pkg::ST_MUL;
      pcf_pkg::ST_MUL:  state_nxt = pcf_pkg::ST_SUB;
      pcf_pkg::ST_SUB:  state_nxt = (k_r + OW'(1) == i_r) ? pcf_pkg::ST_POST : pcf_pkg::ST_RDF;
      pcf_pkg::ST_POST: begin
        if (!is_diag) state_nxt = pcf_pkg::ST_DIV;
        else if (acc_r[AW-1] || acc_r == '0) state_nxt = pcf_pkg::ST_FAIL;
        else state_nxt = pcf_pkg::ST_SQRT;
      end
      pcf_pkg::ST_SQRT: begin
        if (iter_r == pcf_pkg::ITER_W'(pcf_pkg::SQRT_STEPS - 1)) state_nxt = pcf_pkg::ST_WR;
      end
      pcf_pkg::ST_DIV: begin
        if (iter_r == pcf_pkg::ITER_W'(pcf_pkg::DIV_STEPS - 1)) state_nxt = pcf_pkg::ST_WR;
      end
      pcf_pkg::ST_WR: begin
        if ((j_r + OW'(1) == n_eff) && (i_r + OW'(1) == n_eff)) state_nxt = pcf_pkg::ST_EMIT;
        else state_nxt = pcf_pkg::ST_RDIN;
      end
      pcf_pkg::ST_FAIL: if (out_free) state_nxt = pcf_pkg::ST_LOAD;
      pcf_pkg::ST_EMIT: begin
        if (!emit_wait_r && out_free && (emit_r + pcf_pkg::CNT_W'(1) == total))
          state_nxt = pcf_pkg::ST_LOAD;
      end
      default: state_nxt = pcf_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcf_pkg::ST_LOAD;
      order_r     <= OW'(pcf_pkg::MAX_ORDER);
      load_cnt_r  <= '0;
      ov_r        <= 1'b0;
      emit_wait_r <= 1'b1;
      emit_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      iter_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (ov_load) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      if (cfg_wr) begin
        order_r    <= pwdata[OW-1:0];
        load_cnt_r <= '0;
      end else if (in_acc) begin
        if (load_cnt_r + pcf_pkg::CNT_W'(1) >= total) begin
          load_cnt_r <= '0;
          i_r <= '0;
          j_r <= '0;
        end else begin
          load_cnt_r <= load_cnt_r + pcf_pkg::CNT_W'(1);
        end
      end
      unique case (state_r)
        pcf_pkg::ST_INIT: k_r <= '0;
        pcf_pkg::ST_SUB:  k_r <= k_r + OW'(1);
        pcf_pkg::ST_POST: iter_r <= '0;
        pcf_pkg::ST_SQRT, pcf_pkg::ST_DIV: iter_r <= iter_r + pcf_pkg::ITER_W'(1);
        pcf_pkg::ST_WR: begin
          emit_r      <= '0;
          emit_wait_r <= 1'b1;
          if (j_r + OW'(1) != n_eff) begin
            j_r <= j_r + OW'(1);
          end else begin
            i_r <= i_r + OW'(1);
            j_r <= i_r + OW'(1);
          end
        end
        pcf_pkg::ST_EMIT: begin
          if (emit_wait_r) begin
            emit_wait_r <= 1'b0;
          end else if (out_free) begin
            emit_r      <= emit_r + pcf_pkg::CNT_W'(1);
            emit_wait_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    unique case (state_r)
      pcf_pkg::ST_INIT: acc_r <= AW'($signed(in_q)) <<< pcf_pkg::FRACTION_BITS;
      pcf_pkg::ST_MUL:  prod_r <= AW'($signed(fa_q) * $signed(fb_q));
      pcf_pkg::ST_SUB:  acc_r <= sat_sub(acc_r, prod_r);
      pcf_pkg::ST_POST: begin
        rem_r <= '0;
        q_r   <= '0;
        neg_r <= acc_r[AW-1];
        shf_r <= acc_r[AW-1] ? (AW'(0) - acc_r) : acc_r;
      end
      pcf_pkg::ST_SQRT: begin
        rem_r <= sq_ge ? (sq_rem_t - sq_trial) : sq_rem_t;
        q_r   <= {q_r[AW-2:0], sq_ge};
        shf_r <= shf_r << 2;
      end
      pcf_pkg::ST_DIV: begin
        rem_r <= {2'b00, dv_ge ? 32'(dv_rem_t - {1'b0, diag_r}) : dv_rem_t[31:0]};
        q_r   <= {q_r[AW-2:0], dv_ge};
        shf_r <= shf_r << 1;
      end
      pcf_pkg::ST_WR: if (is_diag) diag_r <= res_val;
      pcf_pkg::ST_FAIL: begin
        if (out_free) begin
          oval_r  <= '0;
          onpd_r  <= 1'b1;
          olast_r <= 1'b1;
        end
      end
      pcf_pkg::ST_EMIT: begin
        if (!emit_wait_r && out_free) begin
          oval_r  <= fa_q;
          onpd_r  <= 1'b0;
          olast_r <= (emit_r + pcf_pkg::CNT_W'(1) == total);
        end
      end
      default: ;
    endcase
  end

  assign out_valid                 = ov_r;
  assign out_factor_value          = oval_r;
  assign out_not_positive_definite = onpd_r;
  assign out_last_of_run           = olast_r;

endmodule

>>> hw/rtl/pcf_checker.sv
// Port-level checks of the packed Cholesky factor block, bound to the top level.
module pcf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_factor_value,
  input logic        out_not_positive_definite,
  input logic        out_last_of_run,
  input logic        pready
);

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

  a_fail_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_not_positive_definite) |-> (out_last_of_run && out_factor_value == 32'd0))
    else $error("failure beat malformed");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_factor_value) && $stable(out_last_of_run)))
    else $error("stalled result changed");

endmodule

bind packed_cholesky_factor pcf_checker u_pcf_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_factor_value(out_factor_value),
  .out_not_positive_definite(out_not_positive_definite),
  .out_last_of_run(out_last_of_run),
  .pready(pready)
);

>>> dv/pcf_checker.sv
// Scoreboard for the packed Cholesky factor: tracks order, predicts the factor, checks beats.
`timescale 1ns / 100ps
module pcf_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_element_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_factor_value,
  input  logic        out_not_positive_definite,
  input  logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          error_count,
  output int          pending,
  output int          beats_checked
);

  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
  localparam longint I64_MAX = 64'sh7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [31:0] value;
    logic        npd;
    logic        last;
  } factor_beat_t;

  factor_beat_t    factor_q[$];
  pcf_pkg::order_t order_reg;
  int              fill;
  int              elements[pcf_pkg::DEPTH];

  function automatic int order_in_use();
    if (order_reg < 1) return 1;
    if (order_reg > pcf_pkg::MAX_ORDER) return pcf_pkg::MAX_ORDER;
    return int'(order_reg);
  endfunction

  function automatic longint sub_sat(longint a, longint p);
    if (p > 0 && a < I64_MIN + p) return I64_MIN;
    if (p < 0 && a > I64_MAX + p) return I64_MAX;
    return a - p;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic int divide_sat(longint a, int d);
    longint unsigned mag, q;
    bit neg;
    neg = a < 0;
    mag = neg ? longint'(-(a + 1)) + 64'd1 : a;
    q = mag / longint'(d);
    if (!neg) return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : int'(q);
    if (q >= 64'h8000_0000) return 32'h8000_0000;
    return int'(-longint'(q));
  endfunction

  // Factor the loaded triangle and queue the beats it should produce.
  task automatic predict_factor(int n);
    int lf[pcf_pkg::DEPTH];
    int ri, rj, diag, total;
    longint acc, a2;
    longint unsigned r;
    bit ok;
    ok = 1;
    total = n * (n + 1) / 2;
    for (int i = 0; i < n && ok; i++) begin
      ri = i * (i + 1) / 2;
      acc = longint'(elements[ri + i]) <<< pcf_pkg::FRACTION_BITS;
      for (int k = 0; k < i; k++) acc = sub_sat(acc, longint'(lf[ri + k]) * lf[ri + k]);
      if (acc <= 0) begin
        ok = 0;
      end else begin
        r = root_floor(acc);
        diag = (r > 64'h7fff_ffff) ? 32'h7fff_ffff : int'(r);
        lf[ri + i] = diag;
        for (int j = i + 1; j < n; j++) begin
          rj = j * (j + 1) / 2;
          a2 = longint'(elements[rj + i]) <<< pcf_pkg::FRACTION_BITS;
          for (int k = 0; k < i; k++) a2 = sub_sat(a2, longint'(lf[ri + k]) * lf[rj + k]);
          lf[rj + i] = divide_sat(a2, diag);
        end
      end
    end
    if (!ok) factor_q.push_back('{32'd0, 1'b1, 1'b1});
    else for (int k = 0; k < total; k++)
      factor_q.push_back('{lf[k], 1'b0, k == total - 1});
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    factor_beat_t want;
    int total;
    if (!rst_n) begin
      order_reg = pcf_pkg::order_t'(pcf_pkg::MAX_ORDER);
      fill = 0;
      factor_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == pcf_pkg::REG_ORDER) begin
        order_reg = pwdata[pcf_pkg::ORD_W-1:0];
        fill = 0;
      end
      if (in_valid && !in_stall) begin
        total = order_in_use() * (order_in_use() + 1) / 2;
        if (fill >= total) fill = 0;
        elements[fill] = in_element_value;
        fill++;
        if (fill == total) begin
          fill = 0;
          predict_factor(order_in_use());
        end
      end
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (factor_q.size() == 0) begin
          $display("%0t: result beat %h with nothing expected", $time, out_factor_value);
          error_count++;
        end else begin
          want = factor_q.pop_front();
          if (out_factor_value !== want.value)
            report("factor_value", out_factor_value, want.value);
          if (out_not_positive_definite !== want.npd)
            report("not_positive_definite", 32'(out_not_positive_definite), 32'(want.npd));
          if (out_last_of_run !== want.last)
            report("last_of_run", 32'(out_last_of_run), 32'(want.last));
        end
      end
    end
    pending = factor_q.size();
  end

endmodule

>>> dv/testbench.sv
// Top of the packed Cholesky factor regression: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

  localparam logic [2:0] ORDER_ADDR = {pcf_pkg::REG_ORDER, 2'b00};

  typedef enum int { MAT_DOMINANT, MAT_BROKEN, MAT_NOISE } matrix_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_element_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_factor_value;
  logic        out_not_positive_definite;
  logic        out_last_of_run;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  int error_count, pending, beats_checked;
  int send_idle_pct, recv_stall_pct;
  int cur_order, items_sent, matrices_sent, order_writes;
  int hold_reqs, hold_seen;
  int hold_left;

  packed_cholesky_factor u_top (.*);

  pcf_scoreboard u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (full order-8 matrices with
  // both sides idling most of the time).
  initial begin
    #20_000_000;
    $display("timeout with %0d results still expected", pending);
    $display("packed_cholesky_factor regression: fail");
    $finish;
  end

  // Result side: random stall at the current rate, or a long hold-off when
  // requested. The hold-off is counted here, so the sender keeps offering
  // beats while the block's output register sits full.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 600;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one element; idle first at the current rate, hold until taken.
  // Called and returns at a falling edge, so each step sees one assignment.
  task automatic send_element(logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_element_value <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Program the order only with nothing in flight, after a margin for the
  // block to settle back into loading.
  task automatic write_order(logic [31:0] v);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ORDER_ADDR;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    cur_order = (v[3:0] < 1) ? 1 : (v[3:0] > pcf_pkg::MAX_ORDER) ? pcf_pkg::MAX_ORDER
                : int'(v[3:0]);
    order_writes++;
  endtask

  // Build and send one packed triangle of the current order.
  // Dominant: symmetric, diagonally dominant, so every pivot stays positive.
  // Broken: same, but one diagonal forced to zero or negative.
  // Noise: raw 32-bit words, mostly fails early but hits every bit.
  task automatic send_matrix(matrix_kind_t kind);
    int a[pcf_pkg::MAX_ORDER][pcf_pkg::MAX_ORDER];
    int mag_bits, bad;
    longint sum;
    mag_bits = $urandom_range(27, 2);
    for (int i = 0; i < cur_order; i++)
      for (int j = 0; j < i; j++) begin
        a[i][j] = $urandom_range((1 << mag_bits) * 2) - (1 << mag_bits);
        a[j][i] = a[i][j];
      end
    for (int i = 0; i < cur_order; i++) begin
      sum = 1;
      for (int j = 0; j < cur_order; j++)
        if (j != i) sum += (a[i][j] < 0) ? -a[i][j] : a[i][j];
      sum += $urandom_range(1 << 20);
      a[i][i] = (sum > 64'h7fff_ffff) ? 32'h7fff_ffff : int'(sum);
    end
    if (kind == MAT_BROKEN) begin
      bad = $urandom_range(cur_order - 1);
      a[bad][bad] = $urandom_range(1) ? 0 : -int'($urandom_range(1 << 24, 1));
    end
    for (int i = 0; i < cur_order; i++)
      for (int j = 0; j <= i; j++)
        send_element(kind == MAT_NOISE ? $urandom : a[i][j]);
    matrices_sent++;
  endtask

  initial begin
    matrix_kind_t kind;
    int roll;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_element_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_reqs = 0;
    cur_order = pcf_pkg::MAX_ORDER;
    items_sent = 0;
    matrices_sent = 0;
    order_writes = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: single-element extremes, including zero and negative pivots.
    write_order(1);
    send_element(32'h7fff_ffff);
    send_element(32'h8000_0000);
    send_element(32'h0000_0000);
    send_element(32'h0000_0001);
    send_element(32'hffff_ffff);
    // Order 2: smallest positive first diagonal with the largest negative off-diagonal,
    // which drives the division toward saturation.
    write_order(2);
    send_element(32'h0000_0001);
    send_element(32'h8000_0000);
    send_element(32'h7fff_ffff);
    // Second pivot reduced to exactly zero: [4 2; 2 1].
    send_element(32'h0004_0000);
    send_element(32'h0002_0000);
    send_element(32'h0001_0000);
    // Order rewritten mid-load restarts the triangle.
    write_order(3);
    send_element(32'h0001_0000);
    send_element(32'h0002_0000);
    write_order(2);
    send_matrix(MAT_DOMINANT);
    // Out-of-range orders: zero acts as one, above the maximum acts as max.
    write_order(0);
    send_element(32'h0009_0000);
    write_order(15);
    send_matrix(MAT_DOMINANT);

    // Back-pressure: hold off results across two back-to-back matrices so
    // the block fills and must stall its input.
    write_order(3);
    hold_reqs++;
    send_matrix(MAT_DOMINANT);
    send_matrix(MAT_DOMINANT);

    // Random part, rotating through the idle and stall mixes per matrix.
    while (items_sent < 350) begin
      case (matrices_sent % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if ($urandom_range(5) == 0) begin
        roll = $urandom_range(99);
        write_order(roll < 70 ? $urandom_range(4, 1) : roll < 85 ? pcf_pkg::MAX_ORDER
                    : roll < 92 ? 0 : $urandom_range(15, pcf_pkg::MAX_ORDER + 1));
      end
      // Occasionally abandon a partial triangle with an order write.
      if ($urandom_range(19) == 0 && cur_order > 1) begin
        send_element($urandom);
        write_order(cur_order);
      end
      roll = $urandom_range(99);
      kind = roll < 75 ? MAT_DOMINANT : roll < 90 ? MAT_BROKEN : MAT_NOISE;
      send_matrix(kind);
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected beat, then a short margin.
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("sent %0d elements in %0d matrices over %0d order writes", items_sent,
             matrices_sent, order_writes);
    $display("checked %0d result beats under mixed idle, stall and hold-off", beats_checked);
    if (error_count == 0 && pending == 0) begin
      $display("packed_cholesky_factor regression: pass");
    end else begin
      $display("packed_cholesky_factor regression: fail");
    end
    $finish;
  end

endmodule
